/* sv/sfb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_pkg - square draw framebuffer shared definitions
// Operation codes, field widths, defaults and the structs passed between
// the top level and the drawing engine.
// ----------------------------------------------------------------------------
package sfb_pkg;

	// field widths
	localparam int OP_W    = 2;
	localparam int COORD_W = 6;
	localparam int PIX_W   = 8;
	localparam int SIDE_W  = 7;
	// signed span of x0..x1 (-63 .. 126)
	localparam int SPAN_W  = 8;

	localparam int MAX_SIDE_DEF = 64;
	localparam logic [SIDE_W-1:0] GRID_SIDE_RST = 7'd64;

	// operation codes
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
	localparam logic [OP_W-1:0] OP_OUTLINE = 2'd1;
	localparam logic [OP_W-1:0] OP_FILL    = 2'd2;
	localparam logic [OP_W-1:0] OP_READ    = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [COORD_W-1:0] center_x;
		logic [COORD_W-1:0] center_y;
		logic [COORD_W-1:0] half_width;
		logic [PIX_W-1:0]   color;
	} cmd_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		logic             clipped;
	} res_t;

endpackage

/* sv/sfb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/sfb_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_engine - drawing sequencer
// Takes one command, walks the clipped pixel box one pixel per cycle and
// writes the frame store, or issues a single read; holds the result until
// the output stage takes it.
// ----------------------------------------------------------------------------
module sfb_engine
	import sfb_pkg::*;
#(
	parameter int MAX_SIDE = MAX_SIDE_DEF,
	localparam int DEPTH   = MAX_SIDE * MAX_SIDE,
	localparam int AW      = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	// command transaction
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  cmd_t              cmd,
	input  logic [SIDE_W-1:0] side,
	// result transaction
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res,
	// frame store port
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [PIX_W-1:0]  mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  logic [PIX_W-1:0]  mem_rdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_RDWT = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;

	logic                     in_fire;
	logic signed [SPAN_W-1:0] cx_n, cy_n, hw_n, side_n, smax_n;
	logic signed [SPAN_W-1:0] x0_n, x1_n, y0_n, y1_n;
	logic [SIDE_W-1:0]        xs_n, xe_n, ys_n, ye_n, side_m1;
	logic                     clip_n, empty_n, rd_in_n;

	// walk registers
	logic [OP_W-1:0]          op_q;
	logic [PIX_W-1:0]         color_q;
	logic signed [SPAN_W-1:0] x0_q, x1_q, y0_q, y1_q;
	logic [SIDE_W-1:0]        xs_q, xe_q, ye_q, x_q, y_q;
	logic [AW-1:0]            row_q;
	logic [PIX_W-1:0]         pix_q;
	logic                     clip_q;
	logic                     on_edge;
	logic                     last_col;

	assign in_fire   = cmd_valid && (state_q == ST_IDLE);
	assign cmd_ready = (state_q == ST_IDLE);

	// square bounds and clipping against the active side
	always_comb begin
		cx_n    = signed'(SPAN_W'(cmd.center_x));
		cy_n    = signed'(SPAN_W'(cmd.center_y));
		hw_n    = signed'(SPAN_W'(cmd.half_width));
		side_n  = signed'(SPAN_W'(side));
		smax_n  = side_n - 8'sd1;
		side_m1 = side - 7'd1;
		x0_n    = cx_n - hw_n;
		x1_n    = cx_n + hw_n;
		y0_n    = cy_n - hw_n;
		y1_n    = cy_n + hw_n;
		clip_n  = (x0_n < 0) || (y0_n < 0) || (x1_n > smax_n) || (y1_n > smax_n);
		empty_n = (x0_n > smax_n) || (y0_n > smax_n);
		rd_in_n = (SIDE_W'(cmd.center_x) < side) && (SIDE_W'(cmd.center_y) < side);
		if (cmd.op == OP_CLEAR) begin
			xs_n = '0;
			ys_n = '0;
			xe_n = side_m1;
			ye_n = side_m1;
		end else begin
			xs_n = (x0_n < 0) ? '0 : x0_n[SIDE_W-1:0];
			ys_n = (y0_n < 0) ? '0 : y0_n[SIDE_W-1:0];
			xe_n = (x1_n > smax_n) ? side_m1 : x1_n[SIDE_W-1:0];
			ye_n = (y1_n > smax_n) ? side_m1 : y1_n[SIDE_W-1:0];
		end
	end

	// read issue straight from the accepted command
	assign mem_re    = in_fire && (cmd.op == OP_READ) && rd_in_n;
	assign mem_raddr = AW'(int'(cmd.center_y) * MAX_SIDE + int'(cmd.center_x));

	// outline keeps only pixels on the unclipped square edges
	assign on_edge  = (signed'(SPAN_W'(x_q)) == x0_q) || (signed'(SPAN_W'(x_q)) == x1_q) ||
	                  (signed'(SPAN_W'(y_q)) == y0_q) || (signed'(SPAN_W'(y_q)) == y1_q);
	assign last_col = (x_q == xe_q);

	assign mem_we    = (state_q == ST_WALK) && ((op_q != OP_OUTLINE) || on_edge);
	assign mem_waddr = row_q + AW'(x_q);
	assign mem_wdata = color_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (cmd.op == OP_READ) begin
							state_q <= rd_in_n ? ST_RDWT : ST_DONE;
						end else if (cmd.op != OP_CLEAR && empty_n) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (last_col && (y_q == ye_q)) begin
						state_q <= ST_DONE;
					end
				end
				ST_RDWT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk datapath and result
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q    <= cmd.op;
			color_q <= cmd.color;
			x0_q    <= x0_n;
			x1_q    <= x1_n;
			y0_q    <= y0_n;
			y1_q    <= y1_n;
			xs_q    <= xs_n;
			xe_q    <= xe_n;
			ye_q    <= ye_n;
			x_q     <= xs_n;
			y_q     <= ys_n;
			row_q   <= AW'(int'(ys_n) * MAX_SIDE);
			pix_q   <= '0;
			if (cmd.op == OP_READ) begin
				clip_q <= !rd_in_n;
			end else if (cmd.op == OP_CLEAR) begin
				clip_q <= 1'b0;
			end else begin
				clip_q <= clip_n;
			end
		end else if (state_q == ST_WALK) begin
			if (last_col) begin
				x_q   <= xs_q;
				y_q   <= y_q + 7'd1;
				row_q <= row_q + AW'(MAX_SIDE);
			end else begin
				x_q <= x_q + 7'd1;
			end
		end else if (state_q == ST_RDWT) begin
			pix_q <= mem_rdata;
		end
	end

	assign res_valid       = (state_q == ST_DONE);
	assign res.pixel_value = pix_q;
	assign res.clipped     = clip_q;

endmodule

/* sv/square_draw_framebuffer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_draw_framebuffer_core - square drawing framebuffer
// Row-major 8-bit pixel grid with clear, outline, fill and pixel read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command transaction:
//   op, center_x, center_y, half_width, color. Each command gives exactly
//   one result transaction (pixel_value, clipped) on out_valid/out_ready.
//   Not enforced: user writes grid_side via cfg_we/cfg_wdata only while idle.
// Timing:
//   One command at a time. The engine visits one pixel per cycle over the
//   clipped square's bounding box (the whole active grid for a clear),
//   writing every pixel for a fill or clear and only the edge pixels for
//   an outline. A read goes through the frame store's registered read
//   port; a square fully off the grid skips the walk.
//   The single write port of the frame store sets the drawing rate.
// Reset:
//   grid_side returns to 64 and all handshakes go idle; pixel contents are
//   not cleared and are undefined until first drawn.
// Stall:
//   The result sits in an output register; a new command can be accepted
//   while it waits, and its own result is held in the engine until taken.
// ----------------------------------------------------------------------------
module square_draw_framebuffer_core
	import sfb_pkg::*;
#(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OP_W-1:0]    op,
	input  logic [COORD_W-1:0] center_x,
	input  logic [COORD_W-1:0] center_y,
	input  logic [COORD_W-1:0] half_width,
	input  logic [PIX_W-1:0]   color,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PIX_W-1:0]   pixel_value,
	output logic               clipped,
	// configuration
	input  logic               cfg_we,
	input  logic [SIDE_W-1:0]  cfg_wdata
);

	localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
	localparam int AW       = $clog2(DEPTH);
	localparam int SIDE_CAP = (MAX_SIDE < 127) ? MAX_SIDE : 127;

	logic [SIDE_W-1:0] grid_side_q;
	logic [SIDE_W-1:0] side;
	cmd_t              cmd;
	res_t              res;
	logic              res_valid, res_ready;
	logic              out_valid_q;
	logic [PIX_W-1:0]  pixel_q;
	logic              clipped_q;

	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [PIX_W-1:0]  mem_wdata, mem_rdata;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= GRID_SIDE_RST;
		end else if (cfg_we) begin
			grid_side_q <= cfg_wdata;
		end
	end

	// active side, clamped to 1 .. min(MAX_SIDE, 127)
	always_comb begin
		if (grid_side_q == '0) begin
			side = 7'd1;
		end else if (grid_side_q > SIDE_W'(SIDE_CAP)) begin
			side = SIDE_W'(SIDE_CAP);
		end else begin
			side = grid_side_q;
		end
	end

	assign cmd.op         = op;
	assign cmd.center_x   = center_x;
	assign cmd.center_y   = center_y;
	assign cmd.half_width = half_width;
	assign cmd.color      = color;

	sfb_engine #(
		.MAX_SIDE (MAX_SIDE)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (in_valid),
		.cmd_ready (in_ready),
		.cmd       (cmd),
		.side      (side),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	sfb_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_frame_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			pixel_q   <= res.pixel_value;
			clipped_q <= res.clipped;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_value = pixel_q;
	assign clipped     = clipped_q;

endmodule
